[hw/rtl/rsd_pkg.sv]
package rsd_pkg;

  localparam int ADDR_BITS_DEF = 16;

  localparam int BYTE_W  = 8;
  localparam int ADDR_W  = 16;
  localparam int LEN_W   = 14;

  localparam logic [BYTE_W-1:0] OP_SHORT_RUN   = 8'h00;
  localparam logic [BYTE_W-1:0] OP_LONG_PREFIX = 8'h80;
  localparam logic [15:0]       LONG_STOP      = 16'h0000;

  typedef enum logic [2:0] {
    PH_OPCODE    = 3'd0,
    PH_DUMP      = 3'd1,
    PH_RUN_COUNT = 3'd2,
    PH_RUN_PIXEL = 3'd3,
    PH_LONG_LO   = 3'd4,
    PH_LONG_HI   = 3'd5
  } rsd_phase_t;

  typedef struct packed {
    logic [ADDR_W-1:0] write_address;
    logic [BYTE_W-1:0] fill_value;
    logic [LEN_W-1:0]  fill_length;
    logic              frame_end;
  } rsd_result_t;

endpackage

[hw/rtl/rsd_parser.sv]
module rsd_parser #(
  parameter int ADDR_BITS = rsd_pkg::ADDR_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [rsd_pkg::BYTE_W-1:0]  stream_byte,
  output logic                        res_valid,
  output rsd_pkg::rsd_result_t        res
);
  import rsd_pkg::*;

  rsd_phase_t          phase_r, phase_nxt;
  logic [LEN_W-1:0]    remaining_r, remaining_nxt;
  logic [BYTE_W-1:0]   low_byte_r, low_byte_nxt;
  logic [ADDR_BITS-1:0] dest_r, dest_nxt;

  logic [15:0]         long_word;
  logic [LEN_W-1:0]    remaining_dec;

  assign long_word     = {stream_byte, low_byte_r};
  assign remaining_dec = remaining_r - LEN_W'(1);

  // next state
  always_comb begin
    phase_nxt     = phase_r;
    remaining_nxt = remaining_r;
    low_byte_nxt  = low_byte_r;
    dest_nxt      = dest_r;
    unique case (phase_r)
      PH_DUMP: begin
        dest_nxt      = dest_r + ADDR_BITS'(1);
        remaining_nxt = remaining_dec;
        if (remaining_dec == '0) phase_nxt = PH_OPCODE;
      end
      PH_RUN_COUNT: begin
        remaining_nxt = LEN_W'(stream_byte);
        phase_nxt     = PH_RUN_PIXEL;
      end
      PH_RUN_PIXEL: begin
        dest_nxt      = dest_r + ADDR_BITS'(remaining_r);
        remaining_nxt = '0;
        phase_nxt     = PH_OPCODE;
      end
      PH_LONG_LO: begin
        low_byte_nxt = stream_byte;
        phase_nxt    = PH_LONG_HI;
      end
      PH_LONG_HI: begin
        phase_nxt = PH_OPCODE;
        if (long_word == LONG_STOP) begin
          dest_nxt = '0;
        end else if (!long_word[15]) begin
          dest_nxt = dest_r + ADDR_BITS'(long_word[14:0]);
        end else if (long_word[14]) begin
          remaining_nxt = long_word[LEN_W-1:0];
          phase_nxt     = PH_RUN_PIXEL;
        end else if (long_word[LEN_W-1:0] != '0) begin
          remaining_nxt = long_word[LEN_W-1:0];
          phase_nxt     = PH_DUMP;
        end
      end
      default: begin
        if (stream_byte == OP_SHORT_RUN) begin
          phase_nxt = PH_RUN_COUNT;
        end else if (!stream_byte[7]) begin
          remaining_nxt = LEN_W'(stream_byte);
          phase_nxt     = PH_DUMP;
        end else if (stream_byte == OP_LONG_PREFIX) begin
          phase_nxt = PH_LONG_LO;
        end else begin
          dest_nxt = dest_r + ADDR_BITS'(stream_byte[6:0]);
        end
      end
    endcase
  end

  // result
  always_comb begin
    res_valid         = 1'b0;
    res.write_address = ADDR_W'(dest_r);
    res.fill_value    = stream_byte;
    res.fill_length   = remaining_r;
    res.frame_end     = 1'b0;
    unique case (phase_r)
      PH_DUMP: begin
        res_valid       = accept;
        res.fill_length = LEN_W'(1);
      end
      PH_RUN_PIXEL: begin
        res_valid = accept && (remaining_r != '0);
      end
      PH_LONG_HI: begin
        if (long_word == LONG_STOP) begin
          res_valid       = accept;
          res.fill_value  = '0;
          res.fill_length = '0;
          res.frame_end   = 1'b1;
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_OPCODE;
      remaining_r <= '0;
      low_byte_r  <= '0;
      dest_r      <= '0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      remaining_r <= remaining_nxt;
      low_byte_r  <= low_byte_nxt;
      dest_r      <= dest_nxt;
    end
  end

endmodule

[hw/rtl/rsd_out_skid.sv]
module rsd_out_skid (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  rsd_pkg::rsd_result_t  push_data,
  output logic                  can_take,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output rsd_pkg::rsd_result_t  pop_data
);
  import rsd_pkg::*;

  logic        main_valid_r, main_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  rsd_result_t main_r, main_nxt;
  rsd_result_t skid_r, skid_nxt;
  logic        pop;

  assign pop       = main_valid_r && pop_ready;
  assign can_take  = !skid_valid_r;
  assign pop_valid = main_valid_r;
  assign pop_data  = main_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (pop) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_nxt       = push_data;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

[hw/rtl/run_skip_dump_rle_decoder.sv]
// Frame-delta decoder for run/skip/dump streams. One compressed byte is taken
// per in_ transfer and turned into at most one fill descriptor (address, value,
// length) or an end marker with frame_end set. The parser state updates in the
// cycle the byte is taken; the descriptor is offered on out_ from a register.
// A byte can be taken every cycle: a two-entry output buffer holds results
// while out_ready is low, and in_ready drops only once both entries are full,
// so throughput is one byte per cycle whenever the sink keeps up. Addresses
// wrap modulo 2^ADDR_BITS and write_address shows the low 16 bits.
module run_skip_dump_rle_decoder #(
  parameter int ADDR_BITS = rsd_pkg::ADDR_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rsd_pkg::BYTE_W-1:0]  in_stream_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rsd_pkg::ADDR_W-1:0]  out_write_address,
  output logic [rsd_pkg::BYTE_W-1:0]  out_fill_value,
  output logic [rsd_pkg::LEN_W-1:0]   out_fill_length,
  output logic                        out_frame_end
);
  import rsd_pkg::*;

  logic        accept;
  logic        res_valid;
  rsd_result_t res;
  rsd_result_t out_res;

  assign accept = in_valid && in_ready;

  rsd_parser #(
    .ADDR_BITS (ADDR_BITS)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .stream_byte (in_stream_byte),
    .res_valid   (res_valid),
    .res         (res)
  );

  rsd_out_skid u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .can_take  (in_ready),
    .pop_valid (out_valid),
    .pop_ready (out_ready),
    .pop_data  (out_res)
  );

  assign out_write_address = out_res.write_address;
  assign out_fill_value    = out_res.fill_value;
  assign out_fill_length   = out_res.fill_length;
  assign out_frame_end     = out_res.frame_end;

endmodule

[hw/rtl/rsd_checker.sv]
module rsd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [rsd_pkg::BYTE_W-1:0]  out_fill_value,
  input logic [rsd_pkg::LEN_W-1:0]   out_fill_length,
  input logic                        out_frame_end
);

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // input waits only behind a pending result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  // end marker carries no fill
  a_end_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_fill_length == '0 && out_fill_value == '0)
    else $error("end marker with fill data");

  // zero-length fills are never emitted
  a_no_zero_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_end |-> out_fill_length != '0)
    else $error("zero-length fill emitted");

endmodule

bind run_skip_dump_rle_decoder rsd_checker u_rsd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_fill_value  (out_fill_value),
  .out_fill_length (out_fill_length),
  .out_frame_end   (out_frame_end)
);
